@@ src/apq_pkg.sv @@
package apq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int PRIO_W = 8;
	localparam int DATA_W = 16;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [PRIO_W-1:0] priority_req;
		logic [DATA_W-1:0] payload;
	} req_item_t;

	typedef struct packed {
		status_t           status;
		logic [PRIO_W-1:0] out_priority;
		logic [DATA_W-1:0] out_payload;
	} rsp_item_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

@@ src/array_priority_queue_unit.sv @@
// Channel  Direction  Handshake              Payload
// req      in         req_valid, req_stall   apq_pkg::req_item_t
// rsp      out        rsp_valid, rsp_stall   apq_pkg::rsp_item_t
//
// Each item is handled in the cycle it is accepted; one item per cycle unless the output stalls.
// The entries sit in a row of cells kept sorted by priority, oldest first among equals.
// An insert shifts the lower entries back by one cell and a remove shifts all entries forward.
// The result is held in an output register; a new item is taken while it is free or being taken.
// Reset clears the entry count and the output valid; entry contents are not reset.
module array_priority_queue_unit #(
	parameter int DEPTH = apq_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  apq_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output apq_pkg::rsp_item_t  rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                rsp_valid_q;
	apq_pkg::rsp_item_t  rsp_q;
	logic [CNT_W-1:0]    count_q;
	logic                accept;
	logic                is_full;
	logic                is_empty;
	apq_pkg::cell_ctrl_t ctrl;
	apq_pkg::rsp_item_t  rsp_next;
	apq_pkg::entry_t     entries [DEPTH];
	logic                disp [DEPTH];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept = req_valid && !req_stall;
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		ctrl.ins = accept && (req.mode == apq_pkg::MODE_INSERT) && !is_full;
		ctrl.rem = accept && (req.mode == apq_pkg::MODE_REMOVE) && !is_empty;
		ctrl.new_entry.prio = req.priority_req;
		ctrl.new_entry.data = req.payload;
	end

	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			apq_pkg::entry_t right_in;
			logic            left_disp_in;
			apq_pkg::entry_t left_in;

			if (i == 0) begin : g_head
				assign left_disp_in = 1'b0;
				assign left_in = '0;
			end else begin : g_body
				assign left_disp_in = disp[i-1];
				assign left_in = entries[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign right_in = '0;
			end else begin : g_mid
				assign right_in = entries[i+1];
			end

			apq_cell u_cell (
				.clk            (clk),
				.ctrl           (ctrl),
				.occupied       (CNT_W'(i) < count_q),
				.left_entry     (left_in),
				.left_displaced (left_disp_in),
				.right_entry    (right_in),
				.entry          (entries[i]),
				.displaced      (disp[i])
			);
		end
	endgenerate

	always_comb begin
		rsp_next = '0;
		rsp_next.status = apq_pkg::STATUS_OK;
		if (req.mode == apq_pkg::MODE_INSERT) begin
			if (is_full) begin
				rsp_next.status = apq_pkg::STATUS_FULL;
			end
		end else if (is_empty) begin
			rsp_next.status = apq_pkg::STATUS_EMPTY;
		end else begin
			rsp_next.out_priority = entries[0].prio;
			rsp_next.out_payload = entries[0].data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (ctrl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

@@ src/apq_cell.sv @@
module apq_cell (
	input  logic               clk,
	input  apq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  apq_pkg::entry_t    left_entry,
	input  logic               left_displaced,
	input  apq_pkg::entry_t    right_entry,
	output apq_pkg::entry_t    entry,
	output logic               displaced
);

	apq_pkg::entry_t entry_q;

	// The new entry lands in front of this cell when the cell is empty or its
	// priority is strictly higher, so equal priorities stay in arrival order.
	assign displaced = !occupied || (ctrl.new_entry.prio > entry_q.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && displaced) begin
			entry_q <= left_displaced ? left_entry : ctrl.new_entry;
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int QUEUE_DEPTH = apq_pkg::DEPTH_DEFAULT;
	localparam int PRIO_W = apq_pkg::PRIO_W;
	localparam int DATA_W = apq_pkg::DATA_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	class priority_queue_scoreboard;
		apq_pkg::entry_t    queued_entries[$];
		apq_pkg::rsp_item_t expected_responses[$];
		int                 errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected_responses.size();
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Entries are kept in arrival order; a remove takes the first entry holding the
		// highest priority, so the oldest of equal priorities leaves first.
		task note_request(input apq_pkg::req_item_t item);
			apq_pkg::rsp_item_t expected;
			apq_pkg::entry_t    fresh;
			int                 best;
			expected = '0;
			expected.status = apq_pkg::STATUS_OK;
			if (item.mode == apq_pkg::MODE_INSERT) begin
				if (queued_entries.size() >= QUEUE_DEPTH) begin
					expected.status = apq_pkg::STATUS_FULL;
				end else begin
					fresh.prio = item.priority_req;
					fresh.data = item.payload;
					queued_entries.push_back(fresh);
				end
			end else if (queued_entries.size() == 0) begin
				expected.status = apq_pkg::STATUS_EMPTY;
			end else begin
				best = 0;
				for (int k = 1; k < queued_entries.size(); k++) begin
					if (queued_entries[k].prio > queued_entries[best].prio)
						best = k;
				end
				expected.out_priority = queued_entries[best].prio;
				expected.out_payload = queued_entries[best].data;
				queued_entries.delete(best);
			end
			expected_responses.push_back(expected);
		endtask

		task check_response(input apq_pkg::rsp_item_t got);
			apq_pkg::rsp_item_t want;
			if (expected_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d prio=%0d data=%h",
					got.status, got.out_priority, got.out_payload));
			end else begin
				want = expected_responses.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
				if (got.out_priority !== want.out_priority)
					report_mismatch($sformatf("out_priority %0d, expected %0d",
						got.out_priority, want.out_priority));
				if (got.out_payload !== want.out_payload)
					report_mismatch($sformatf("out_payload %h, expected %h",
						got.out_payload, want.out_payload));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	apq_pkg::req_item_t req;
	logic               rsp_valid;
	logic               rsp_stall;
	apq_pkg::rsp_item_t rsp;

	priority_queue_scoreboard sb;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_cycles = 0;
	int quiet_cycles = 0;

	array_priority_queue_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_response(rsp);
		if (req_valid && !req_stall)
			sb.note_request(req);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver holds off for a long stretch on request while the sender keeps going.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (holdoff_cycles) @(posedge clk);
				holdoff_cycles = 0;
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_request(input apq_pkg::req_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_insert(input logic [PRIO_W-1:0] prio, input logic [DATA_W-1:0] data);
		apq_pkg::req_item_t item;
		item.mode = apq_pkg::MODE_INSERT;
		item.priority_req = prio;
		item.payload = data;
		send_request(item);
	endtask

	task automatic send_remove();
		apq_pkg::req_item_t item;
		item.mode = apq_pkg::MODE_REMOVE;
		item.priority_req = PRIO_W'($urandom_range(255));
		item.payload = DATA_W'($urandom_range(65535));
		send_request(item);
	endtask

	// Small priority values give many ties; the extremes come up often on their own.
	task automatic send_random(input int insert_pct);
		logic [PRIO_W-1:0] prio;
		int                pick;
		pick = $urandom_range(99);
		if (pick < 25)
			prio = PRIO_W'($urandom_range(3));
		else if (pick < 35)
			prio = $urandom_range(1) ? 8'hFF : 8'h00;
		else
			prio = PRIO_W'($urandom_range(255));
		if ($urandom_range(99) < insert_pct)
			send_insert(prio, DATA_W'($urandom_range(65535)));
		else
			send_remove();
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// The insert share changes every few dozen items so the fill level swings between
	// empty and full.
	task automatic run_phase(input int count, input int idle_pct, input int stall_share,
		input int holdoff_at);
		int insert_pct;
		send_idle_pct = idle_pct;
		stall_pct = stall_share;
		insert_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 25;
					1: insert_pct = 50;
					default: insert_pct = 75;
				endcase
			end
			if (i == holdoff_at)
				holdoff_cycles = 80;
			send_random(insert_pct);
		end
		drain();
	endtask

	initial begin
		sb = new();
		req_valid <= 1'b0;
		req <= '0;
		@(posedge arst_n);
		@(posedge clk);

		send_remove();
		send_insert(8'h00, 16'h0000);
		send_insert(8'hFF, 16'hFFFF);
		send_insert(8'h80, 16'h1234);
		send_insert(8'hFF, 16'h0001);
		send_insert(8'h00, 16'hFFFF);
		for (int k = 0; k < QUEUE_DEPTH - 5; k++)
			send_insert(8'h07, DATA_W'(k));
		send_insert(8'hFF, 16'hAAAA);
		repeat (6) send_remove();
		drain();

		run_phase(375, 0, 0, 100);
		run_phase(375, 73, 0, -1);
		run_phase(375, 0, 73, -1);
		run_phase(375, 16, 16, 200);
		run_phase(375, 0, 0, -1);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
src/apq_pkg.sv
src/apq_cell.sv
src/array_priority_queue_unit.sv
dv/testbench.sv
